### hw/rtl/ssc_pkg.sv
// ssc_pkg: shared types and codes for the stream session controller
// no dependencies; used by every module of the block

package ssc_pkg;

  localparam int unsigned SessW   = 32;
  localparam int unsigned ClientW = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned CodecW  = 8;
  localparam int unsigned TmoW    = 32;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCodecMask = 1'd1;

  localparam logic [TmoW-1:0]   TimeoutReset   = 32'd5000000;
  localparam logic [CodecW-1:0] CodecMaskReset = 8'd1;

  // packet message types as they arrive on msg_type
  localparam logic [2:0] MsgHello    = 3'd0;
  localparam logic [2:0] MsgStart    = 3'd1;
  localparam logic [2:0] MsgPing     = 3'd2;
  localparam logic [2:0] MsgKeyReq   = 3'd3;
  localparam logic [2:0] MsgFeedback = 3'd4;
  localparam logic [2:0] MsgBye      = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_READY  = 2'd1,
    PH_STREAM = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_HELLO  = 2'd1,
    SEND_REJECT = 2'd2,
    SEND_PONG   = 2'd3
  } send_e;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_START      = 2'd1,
    EV_KEYFRAME   = 2'd2,
    EV_DISCONNECT = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CMD_IGNORE   = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_HELLO    = 3'd2,
    CMD_START    = 3'd3,
    CMD_PING     = 3'd4,
    CMD_KEYREQ   = 3'd5,
    CMD_FEEDBACK = 3'd6,
    CMD_BYE      = 3'd7
  } cmd_kind_e;

  // classified beat handed from front to back
  typedef struct packed {
    cmd_kind_e          kind;
    logic [SessW-1:0]   session;
    logic [ClientW-1:0] client;
    logic [SessW-1:0]   new_sid;
    logic               codec_ok;
    logic [TimeW-1:0]   now;
  } cmd_t;

endpackage

### hw/rtl/stream_session_controller.sv
// stream_session_controller: top level of the single-client session controller
// depends on ssc_pkg, ssc_front, ssc_queue, ssc_back

// Takes one packet or timer-tick beat per cycle while in_stall_o is low and
// returns exactly one result beat for each, in order. A beat passes a classify
// register in the front, a two-entry queue and the session stage in the back,
// which updates phase, session id, bound client and last-heard time and
// registers the result. The session stage handles one beat per cycle unless a
// stalled output holds it, with a 64-bit idle-time subtract and compare.
// Configuration writes take effect at once and belong between traffic;
// timeout_us is index 0, required_codec_mask index 1.

module stream_session_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ssc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          header_ok_i,
  input  logic [2:0]                    msg_type_i,
  input  logic                          payload_ok_i,
  input  logic [ssc_pkg::SessW-1:0]     pkt_session_i,
  input  logic [ssc_pkg::ClientW-1:0]   pkt_client_i,
  input  logic [ssc_pkg::CodecW-1:0]    offered_codecs_i,
  input  logic [ssc_pkg::TimeW-1:0]     now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [1:0]                    send_kind_o,
  output logic [1:0]                    event_res_o,
  output logic [ssc_pkg::SessW-1:0]     out_session_o,
  output logic [ssc_pkg::TimeW-1:0]     ack_timebase_o
);

  logic [ssc_pkg::TmoW-1:0]   timeout_q, timeout_d;
  logic [ssc_pkg::CodecW-1:0] mask_q, mask_d;

  logic          fq_valid, fq_ready;
  ssc_pkg::cmd_t fq_cmd;
  logic          qb_valid, qb_ready;
  ssc_pkg::cmd_t qb_cmd;

  always_comb begin
    timeout_d = timeout_q;
    mask_d    = mask_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ssc_pkg::CfgTimeout:   timeout_d = cfg_data_i[ssc_pkg::TmoW-1:0];
        ssc_pkg::CfgCodecMask: mask_d    = cfg_data_i[ssc_pkg::CodecW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ssc_pkg::TimeoutReset;
      mask_q    <= ssc_pkg::CodecMaskReset;
    end else begin
      timeout_q <= timeout_d;
      mask_q    <= mask_d;
    end
  end

  ssc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .header_ok_i      (header_ok_i),
    .msg_type_i       (msg_type_i),
    .payload_ok_i     (payload_ok_i),
    .pkt_session_i    (pkt_session_i),
    .pkt_client_i     (pkt_client_i),
    .offered_codecs_i (offered_codecs_i),
    .now_us_i         (now_us_i),
    .codec_mask_i     (mask_q),
    .cmd_valid_o      (fq_valid),
    .cmd_ready_i      (fq_ready),
    .cmd_o            (fq_cmd)
  );

  ssc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_cmd_o    (qb_cmd)
  );

  ssc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (qb_valid),
    .cmd_ready_o    (qb_ready),
    .cmd_i          (qb_cmd),
    .timeout_i      (timeout_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .send_kind_o    (send_kind_o),
    .event_res_o    (event_res_o),
    .out_session_o  (out_session_o),
    .ack_timebase_o (ack_timebase_o)
  );

endmodule

### hw/rtl/ssc_front.sv
// ssc_front: accepts input beats, classifies them and precomputes hello fields
// depends on ssc_pkg

module ssc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          header_ok_i,
  input  logic [2:0]                    msg_type_i,
  input  logic                          payload_ok_i,
  input  logic [ssc_pkg::SessW-1:0]     pkt_session_i,
  input  logic [ssc_pkg::ClientW-1:0]   pkt_client_i,
  input  logic [ssc_pkg::CodecW-1:0]    offered_codecs_i,
  input  logic [ssc_pkg::TimeW-1:0]     now_us_i,
  input  logic [ssc_pkg::CodecW-1:0]    codec_mask_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output ssc_pkg::cmd_t                 cmd_o
);

  logic               valid_q, valid_d;
  ssc_pkg::cmd_t      cmd_q, cmd_d;
  logic               load;
  logic [ssc_pkg::SessW-1:0] mix;

  assign in_stall_o = valid_q && !cmd_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    // session id mixed from both time halves and the client id, zero maps to one
    mix = now_us_i[31:0] ^ now_us_i[63:32] ^ pkt_client_i;
    cmd_d.session  = pkt_session_i;
    cmd_d.client   = pkt_client_i;
    cmd_d.new_sid  = (mix == '0) ? ssc_pkg::SessW'(1) : mix;
    cmd_d.codec_ok = (offered_codecs_i & codec_mask_i) != '0;
    cmd_d.now      = now_us_i;
    cmd_d.kind     = ssc_pkg::CMD_IGNORE;
    if (mode_i) begin
      cmd_d.kind = ssc_pkg::CMD_TICK;
    end else if (header_ok_i) begin
      case (msg_type_i)
        ssc_pkg::MsgHello:    cmd_d.kind = payload_ok_i ? ssc_pkg::CMD_HELLO
                                                        : ssc_pkg::CMD_IGNORE;
        ssc_pkg::MsgStart:    cmd_d.kind = ssc_pkg::CMD_START;
        ssc_pkg::MsgPing:     cmd_d.kind = payload_ok_i ? ssc_pkg::CMD_PING
                                                        : ssc_pkg::CMD_IGNORE;
        ssc_pkg::MsgKeyReq:   cmd_d.kind = ssc_pkg::CMD_KEYREQ;
        ssc_pkg::MsgFeedback: cmd_d.kind = ssc_pkg::CMD_FEEDBACK;
        ssc_pkg::MsgBye:      cmd_d.kind = ssc_pkg::CMD_BYE;
        default:              cmd_d.kind = ssc_pkg::CMD_IGNORE;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

### hw/rtl/ssc_queue.sv
// ssc_queue: two-entry queue of classified beats between front and back
// depends on ssc_pkg

module ssc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ssc_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ssc_pkg::cmd_t pop_cmd_o
);

  ssc_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          push, pop;

  assign push_ready_o = count_q != 2'd2;
  assign pop_valid_o  = count_q != 2'd0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### hw/rtl/ssc_back.sv
// ssc_back: session state, command execution and the registered result stage
// depends on ssc_pkg

module ssc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  ssc_pkg::cmd_t               cmd_i,
  input  logic [ssc_pkg::TmoW-1:0]    timeout_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o,
  output logic [1:0]                  send_kind_o,
  output logic [1:0]                  event_res_o,
  output logic [ssc_pkg::SessW-1:0]   out_session_o,
  output logic [ssc_pkg::TimeW-1:0]   ack_timebase_o
);

  ssc_pkg::phase_e              phase_q, phase_d;
  logic [ssc_pkg::SessW-1:0]    sess_q, sess_d;
  logic [ssc_pkg::ClientW-1:0]  client_q, client_d;
  logic [ssc_pkg::TimeW-1:0]    last_q, last_d;

  logic                         out_valid_q, out_valid_d;
  logic                         acc_q, acc_d;
  ssc_pkg::send_e               send_q, send_d;
  ssc_pkg::event_e              ev_q, ev_d;
  logic [ssc_pkg::SessW-1:0]    osess_q;
  logic [ssc_pkg::TimeW-1:0]    tb_q, tb_d;

  logic                         take;
  logic                         open, match, streaming, timed_out, same_client;
  logic [ssc_pkg::TimeW-1:0]    elapsed;

  assign cmd_ready_o = !out_valid_q || !out_stall_i;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign open        = phase_q != ssc_pkg::PH_IDLE;
  assign streaming   = phase_q == ssc_pkg::PH_STREAM;
  assign match       = open && (cmd_i.session == sess_q);
  assign same_client = cmd_i.client == client_q;
  // wrapping idle time
  assign elapsed     = cmd_i.now - last_q;
  assign timed_out   = open && (elapsed > {{(ssc_pkg::TimeW-ssc_pkg::TmoW){1'b0}}, timeout_i});

  // next session state
  always_comb begin
    phase_d  = phase_q;
    sess_d   = sess_q;
    client_d = client_q;
    last_d   = last_q;
    if (take) begin
      case (cmd_i.kind)
        ssc_pkg::CMD_TICK: begin
          if (timed_out) begin
            phase_d  = ssc_pkg::PH_IDLE;
            sess_d   = '0;
            client_d = '0;
          end
        end
        ssc_pkg::CMD_HELLO: begin
          if (open && same_client) begin
            last_d = cmd_i.now;
          end else if (!open && cmd_i.codec_ok) begin
            phase_d  = ssc_pkg::PH_READY;
            sess_d   = cmd_i.new_sid;
            client_d = cmd_i.client;
            last_d   = cmd_i.now;
          end
        end
        ssc_pkg::CMD_START: begin
          if (match) begin
            last_d  = cmd_i.now;
            phase_d = ssc_pkg::PH_STREAM;
          end
        end
        ssc_pkg::CMD_PING, ssc_pkg::CMD_FEEDBACK: begin
          if (match) begin
            last_d = cmd_i.now;
          end
        end
        ssc_pkg::CMD_KEYREQ: begin
          if (streaming && cmd_i.session == sess_q) begin
            last_d = cmd_i.now;
          end
        end
        ssc_pkg::CMD_BYE: begin
          if (match) begin
            phase_d  = ssc_pkg::PH_IDLE;
            sess_d   = '0;
            client_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    acc_d  = 1'b0;
    send_d = ssc_pkg::SEND_NONE;
    ev_d   = ssc_pkg::EV_NONE;
    tb_d   = '0;
    case (cmd_i.kind)
      ssc_pkg::CMD_TICK: begin
        if (timed_out) begin
          ev_d = ssc_pkg::EV_DISCONNECT;
        end
      end
      ssc_pkg::CMD_HELLO: begin
        if ((open && !same_client) || (!open && !cmd_i.codec_ok)) begin
          send_d = ssc_pkg::SEND_REJECT;
        end else begin
          send_d = ssc_pkg::SEND_HELLO;
          tb_d   = cmd_i.now;
          acc_d  = 1'b1;
        end
      end
      ssc_pkg::CMD_START: begin
        if (match) begin
          acc_d = 1'b1;
          if (!streaming) begin
            ev_d = ssc_pkg::EV_START;
          end
        end
      end
      ssc_pkg::CMD_PING: begin
        if (match) begin
          send_d = ssc_pkg::SEND_PONG;
          acc_d  = 1'b1;
        end
      end
      ssc_pkg::CMD_KEYREQ: begin
        if (streaming && cmd_i.session == sess_q) begin
          ev_d  = ssc_pkg::EV_KEYFRAME;
          acc_d = 1'b1;
        end
      end
      ssc_pkg::CMD_FEEDBACK: begin
        acc_d = match;
      end
      ssc_pkg::CMD_BYE: begin
        if (match) begin
          ev_d = ssc_pkg::EV_DISCONNECT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ssc_pkg::PH_IDLE;
      sess_q      <= '0;
      client_q    <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      sess_q      <= sess_d;
      client_q    <= client_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q   <= acc_d;
      send_q  <= send_d;
      ev_q    <= ev_d;
      osess_q <= sess_d;
      tb_q    <= tb_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign send_kind_o    = send_q;
  assign event_res_o    = ev_q;
  assign out_session_o  = osess_q;
  assign ack_timebase_o = tb_q;

endmodule
